FILE: rtl/b64lw_pkg.sv
// Package for the line-wrapped base64 encoder: job record, character codes,
// line and queue sizes, and the sextet-to-character map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64lw_pkg;

  // Bytes per output line; 48 bytes give 64 characters a line.
  localparam int LINE_BYTES = 48;
  localparam int LINE_POS_W = $clog2(LINE_BYTES);

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] NEWLINE_CHAR = 7'h0A;
  localparam logic [6:0] PAD_CHAR     = 7'h3D;

  // Character slots within one job: the newline, then four group characters.
  localparam logic [2:0] SLOT_NL    = 3'd0;
  localparam logic [2:0] SLOT_FIRST = 3'd1;
  localparam logic [2:0] SLOT_LAST  = 3'd4;

  // Number of alphabet characters in a group; the rest of the four are padding.
  localparam logic [2:0] NSEXT_ONE_BYTE  = 3'd2;
  localparam logic [2:0] NSEXT_TWO_BYTES = 3'd3;
  localparam logic [2:0] NSEXT_FULL      = 3'd4;

  typedef struct packed {
    logic        nl;     // newline leads the job
    logic        grp;    // four group characters follow
    logic [2:0]  nsext;  // alphabet characters among those four
    logic [23:0] word;   // group bits, oldest byte high
  } job_t;

  typedef logic [2:0] slot_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) begin
      return 7'd65 + {1'b0, s};
    end else if (s < 6'd52) begin
      return 7'd71 + {1'b0, s};
    end else if (s < 6'd62) begin
      return {1'b0, s} - 7'd4;
    end else if (s == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b64lw_front.sv
// Front end of the encoder: takes bytes, tracks group and line position,
// and turns each byte that prints anything into a job record. Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [7:0]         data_byte,
  input  wire                end_of_data,
  input  wire                q_full,
  output logic               q_push,
  output b64lw_pkg::job_t    q_job
);
  import b64lw_pkg::*;

  logic [15:0]           pending_bytes;
  logic [1:0]            group_phase;
  logic [LINE_POS_W-1:0] line_position;
  logic                  seen_first_byte;
  logic                  accept;

  always_comb begin
    in_stall = q_full;
    accept   = in_valid && !q_full;

    q_job.nl  = seen_first_byte && (line_position == '0);
    q_job.grp = (group_phase == 2'd2) || end_of_data;
    unique case (group_phase)
      2'd0: begin
        q_job.nsext = NSEXT_ONE_BYTE;
        q_job.word  = {data_byte, 16'h0000};
      end
      2'd1: begin
        q_job.nsext = NSEXT_TWO_BYTES;
        q_job.word  = {pending_bytes[7:0], data_byte, 8'h00};
      end
      default: begin
        q_job.nsext = NSEXT_FULL;
        q_job.word  = {pending_bytes, data_byte};
      end
    endcase

    // Drop bytes that only fill the group: nothing to print for them.
    q_push = accept && (q_job.nl || q_job.grp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes   <= '0;
      group_phase     <= '0;
      line_position   <= '0;
      seen_first_byte <= 1'b0;
    end else if (accept) begin
      if (end_of_data) begin
        pending_bytes   <= '0;
        group_phase     <= '0;
        line_position   <= '0;
        seen_first_byte <= 1'b0;
      end else begin
        seen_first_byte <= 1'b1;
        if (line_position == LINE_POS_W'(LINE_BYTES - 1)) begin
          line_position <= '0;
        end else begin
          line_position <= line_position + 1'b1;
        end
        unique case (group_phase)
          2'd0: begin
            pending_bytes <= {8'h00, data_byte};
            group_phase   <= 2'd1;
          end
          2'd1: begin
            pending_bytes <= {pending_bytes[7:0], data_byte};
            group_phase   <= 2'd2;
          end
          default: begin
            pending_bytes <= '0;
            group_phase   <= 2'd0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64lw_queue.sv
// Short job queue between the front and back ends of the encoder.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  b64lw_pkg::job_t    push_job,
  output logic               full,
  input  wire                pop,
  output b64lw_pkg::job_t    pop_job,
  output logic               empty
);
  import b64lw_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_comb begin
    full    = (count == QCNT_W'(QUEUE_DEPTH));
    empty   = (count == '0);
    pop_job = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64lw_back.sv
// Back end of the encoder: walks each job one character a cycle into the
// output register while that register is free. Depends on b64lw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64lw_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_empty,
  input  b64lw_pkg::job_t    q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [6:0]         out_char,
  output logic               run_last
);
  import b64lw_pkg::*;

  logic       active;
  job_t       cur_job;
  slot_t      pos;
  slot_t      end_pos;
  logic       out_free;
  logic       finish;
  logic [5:0] sextet;
  logic [6:0] cur_char;

  always_comb begin
    out_free = !out_valid || !out_stall;
    end_pos  = cur_job.grp ? SLOT_LAST : SLOT_NL;
    finish   = active && out_free && (pos == end_pos);
    q_pop    = !q_empty && (!active || finish);

    case (pos)
      3'd1:    sextet = cur_job.word[23:18];
      3'd2:    sextet = cur_job.word[17:12];
      3'd3:    sextet = cur_job.word[11:6];
      default: sextet = cur_job.word[5:0];
    endcase

    if (pos == SLOT_NL) begin
      cur_char = NEWLINE_CHAR;
    end else if (pos <= cur_job.nsext) begin
      cur_char = sextet_char(sextet);
    end else begin
      cur_char = PAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= SLOT_NL;
    end else begin
      if (out_free) begin
        out_valid <= active;
      end
      if (q_pop) begin
        active <= 1'b1;
        pos    <= q_job.nl ? SLOT_NL : SLOT_FIRST;
      end else if (finish) begin
        active <= 1'b0;
      end else if (active && out_free) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active && out_free) begin
      out_char <= cur_char;
      run_last <= (pos == end_pos);
    end
    if (q_pop) begin
      cur_job <= q_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/base64_line_wrapped_encoder_unit.sv
// Top level of the line-wrapped base64 encoder: front end, job queue, back end.
// Depends on b64lw_pkg, b64lw_front, b64lw_queue, b64lw_back.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   input   | in_valid / in_stall  | data_byte[7:0], end_of_data
//   output  | out_valid / out_stall| out_char[6:0], run_last
//
// The front end takes one byte every cycle while the job queue has room and
// turns each byte that prints anything into a job (optional newline,
// optional four group characters). The back end prints one character a cycle
// from the output register while out_stall is low; a group is four characters,
// five with a line break, and throughput is set by the single output character register.
// An item passes the job queue and the back end's job register before reaching the output register.
// Reset (rst, synchronous) clears the group, line and queue state and drops
// the output item. out_stall holds the output item; the back end then waits,
// the queue fills and in_stall rises once it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder_unit (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] data_byte,
  input  wire        end_of_data,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [6:0] out_char,
  output logic       run_last
);
  import b64lw_pkg::*;

  // Jobs handed from the front end to the queue, and from the queue onward.
  job_t push_job;
  job_t pop_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  b64lw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  b64lw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Advance one character a cycle whenever the output register frees up.
  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .run_last  (run_last)
  );

`ifndef SYNTHESIS
  // Within one job the back end never starves: the next character follows.
  a_no_gap_in_job: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a character run");

  // Padding that is not last is followed straight by more padding, which ends
  // the run.
  a_pad_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (out_char == PAD_CHAR) && !run_last
    |=> (out_char == PAD_CHAR) && run_last)
    else $error("broken padding run");

  // A newline that does not end its run is followed by an alphabet character.
  a_nl_then_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (out_char == NEWLINE_CHAR) && !run_last
    |=> (out_char != NEWLINE_CHAR) && (out_char != PAD_CHAR))
    else $error("newline not followed by a group character");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_base64_line_wrapped_encoder_unit.sv
// Self-checking testbench for the line-wrapped base64 encoder: byte streams in,
// predicted characters checked in order against the output channel.
// Depends on b64lw_pkg and base64_line_wrapped_encoder_unit.
`timescale 1ns / 1ps

module tb_base64_line_wrapped_encoder_unit;
  import b64lw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // generous ceiling for the whole run
  localparam int HOLD_CYCLES = 160;     // long receiver hold-off, fills the job queue
  localparam int HOLD_AT     = 25;      // bytes offered before the hold-off starts
  localparam int CALM_FROM   = 70;      // byte window with no idling on either side
  localparam int CALM_TO     = 110;
  localparam int IDLE_PCT    = 17;
  localparam int DRAIN_WAIT  = 16;      // settling cycles once nothing is due
  localparam int RANDOM_BYTES = 130;    // random bytes after the directed ones
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_data = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       run_last;

  // Bytes still to be offered, and characters owed by the encoder.
  raw_byte_t feed_q[$];
  enc_char_t chars_due[$];

  // Shadow encoder state: open group, fill level, byte column, stream started.
  logic [15:0]           grp_bytes = '0;
  logic [1:0]            grp_fill = '0;
  logic [LINE_POS_W-1:0] col_byte = '0;
  logic                  stream_open = 1'b0;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int   cycle_count = 0;
  int   items_sent = 0;
  int   bytes_taken = 0;
  int   bytes_total = 0;
  int   streams_total = 0;
  int   chars_checked = 0;
  int   peak_chars = 0;
  int   fault_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic in_taken = 1'b0;
  logic timed_out = 1'b0;
  logic calm;

  assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

  base64_line_wrapped_encoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] b64_symbol(input logic [5:0] s);
    byte c;
    c = b64_alphabet.getc(int'(s));
    return c[6:0];
  endfunction

  task automatic note_fault(input string what, input int exp_v, input int act_v);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h", $time, what, exp_v, act_v);
    end
  endtask

  // Work out the characters that one accepted byte owes, and advance the
  // shadow state. The final character of the byte carries the run marker.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [6:0]  chars [5];
    logic [23:0] word;
    logic [11:0] tail1;
    logic [17:0] tail2;
    enc_char_t   c;
    int          n;
    n = 0;
    if (stream_open && col_byte == 0) begin
      chars[n] = NEWLINE_CHAR;
      n++;
    end
    if (grp_fill == 2'd2) begin
      word = {grp_bytes, b};
      chars[n]   = b64_symbol(word[23:18]);
      chars[n+1] = b64_symbol(word[17:12]);
      chars[n+2] = b64_symbol(word[11:6]);
      chars[n+3] = b64_symbol(word[5:0]);
      n += 4;
      grp_bytes = '0;
      grp_fill = 2'd0;
    end else if (grp_fill == 2'd1) begin
      grp_bytes = {grp_bytes[7:0], b};
      grp_fill = 2'd2;
    end else begin
      grp_bytes = {8'h00, b};
      grp_fill = 2'd1;
    end
    stream_open = 1'b1;
    if (int'(col_byte) + 1 >= LINE_BYTES) begin
      col_byte = '0;
    end else begin
      col_byte = col_byte + 1'b1;
    end
    if (last) begin
      // Flush a partial group with padding, then start a fresh stream.
      if (grp_fill == 2'd1) begin
        tail1 = {grp_bytes[7:0], 4'h0};
        chars[n]   = b64_symbol(tail1[11:6]);
        chars[n+1] = b64_symbol(tail1[5:0]);
        chars[n+2] = PAD_CHAR;
        chars[n+3] = PAD_CHAR;
        n += 4;
      end else if (grp_fill == 2'd2) begin
        tail2 = {grp_bytes, 2'b00};
        chars[n]   = b64_symbol(tail2[17:12]);
        chars[n+1] = b64_symbol(tail2[11:6]);
        chars[n+2] = b64_symbol(tail2[5:0]);
        chars[n+3] = PAD_CHAR;
        n += 4;
      end
      grp_bytes = '0;
      grp_fill = 2'd0;
      col_byte = '0;
      stream_open = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      c.ch = chars[i];
      c.last = (i == n - 1);
      chars_due.push_back(c);
    end
    if (n > peak_chars) begin
      peak_chars = n;
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    raw_byte_t r;
    r.data = b;
    r.last = last;
    feed_q.push_back(r);
    bytes_total++;
    if (last) begin
      streams_total++;
    end
  endtask

  task automatic add_stream(input int len);
    for (int i = 0; i < len; i++) begin
      add_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Driver: offer the next byte at the falling edge once the current one has
  // gone in; idle now and then, never inside the calm window.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        data_byte   <= feed_q[0].data;
        end_of_data <= feed_q[0].last;
        in_valid    <= 1'b1;
        items_sent  <= items_sent + 1;
        feed_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, hold off once for a long stretch so that the
  // encoder backs up into its input, and never stall in the calm window.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: check each character taken against the oldest one owed, then
  // predict the characters for any byte taken at this edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (chars_due.size() == 0) begin
          note_fault("unexpected character", 0, int'(out_char));
        end else begin
          if (chars_due[0].ch !== out_char) begin
            note_fault("out_char", int'(chars_due[0].ch), int'(out_char));
          end
          if (chars_due[0].last !== run_last) begin
            note_fault("run_last", int'(chars_due[0].last), int'(run_last));
          end
          chars_due.delete(0);
          chars_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, end_of_data);
        bytes_taken++;
      end
    end
  end

  initial begin
    int len;
    int len_next;

    // Directed streams: one-byte and two-byte flushes at the byte extremes,
    // a complete group on the final byte, then groups of '+', '/', digits
    // and lower case, ending on a full group so no padding follows.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h10, 1'b0);
    add_byte(8'h83, 1'b1);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hD3, 1'b0);
    add_byte(8'h4D, 1'b0);
    add_byte(8'h34, 1'b0);
    add_byte(8'h69, 1'b0);
    add_byte(8'hA6, 1'b0);
    add_byte(8'h9A, 1'b1);

    // Random streams: a line break landing on the final byte (one byte left
    // over, the busiest byte), a break followed by a two-byte flush, then
    // mostly short streams with a few that run over a line, trimmed so the
    // byte budget is met exactly.
    len = bytes_total;
    add_stream(LINE_BYTES + 1);
    add_stream(LINE_BYTES + 2);
    while (bytes_total - len < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        len_next = $urandom_range(LINE_BYTES - 3, 2 * LINE_BYTES + 2);
      end else begin
        len_next = $urandom_range(1, 12);
      end
      if (len_next > RANDOM_BYTES - (bytes_total - len)) begin
        len_next = RANDOM_BYTES - (bytes_total - len);
      end
      add_stream(len_next);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        while (bytes_taken < bytes_total || chars_due.size() != 0) begin
          @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(negedge clk);
        end
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && chars_due.size() != 0) begin
      $display("%0d characters never arrived", chars_due.size());
      fault_count += chars_due.size();
    end
    $display("encoded %0d bytes in %0d streams, %0d characters checked",
             bytes_taken, streams_total, chars_checked);
    $display("busiest byte gave %0d characters; %0d-cycle receiver hold-off applied",
             peak_chars, HOLD_CYCLES);
    if (!timed_out && fault_count == 0) begin
      $display("base64_line_wrapped_encoder_unit verification clean");
    end else begin
      $display("base64_line_wrapped_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
